[rtl/core/cgs_pkg.sv]
// Shared types, constants and helper functions for the cell grid store.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cgs_pkg;

   localparam int MAX_WIDTH_DEF = 64;
   localparam int MAX_DEPTH_DEF = 64;
   localparam int CELL_BITS_DEF = 4;

   localparam int CODE_W     = 4;
   localparam int GEO_W      = 7;
   localparam int COORD_W    = 8;
   localparam int MODE_W     = 3;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int PT_W       = 9;
   localparam int PROD_W     = 17;
   localparam int IDX_W      = 18;
   localparam int SIZE_W     = 14;
   localparam int NBR_W      = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [CODE_W-1:0] CARD_BORDER = 4'd5;
   localparam logic [CODE_W-1:0] ALL_BORDER  = 4'd9;
   localparam logic [CODE_W-1:0] FLOOR_RST   = 4'd1;
   localparam logic [CODE_W-1:0] EMPTY_RST   = 4'd0;
   localparam logic [CODE_W-1:0] INVALID_RST = 4'd15;

   localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DEPTH   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EMPTY   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INVALID = 3'd4;

   localparam logic [NBR_W-1:0] NBR_CARD_FIRST = 3'd0;
   localparam logic [NBR_W-1:0] NBR_CARD_LAST  = 3'd3;
   localparam logic [NBR_W-1:0] NBR_DIAG_FIRST = 3'd4;
   localparam logic [NBR_W-1:0] NBR_DIAG_LAST  = 3'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 3'd0,
      MODE_READ  = 3'd1,
      MODE_FILL  = 3'd2,
      MODE_CARD  = 3'd3,
      MODE_DIAG  = 3'd4,
      MODE_ALL   = 3'd5,
      MODE_CLEAR = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      PT_CENTER     = 3'd0,
      PT_NBR        = 3'd1,
      PT_CORNER2    = 3'd2,
      PT_FILL_START = 3'd3,
      PT_FILL_NEXT  = 3'd4
   } pt_sel_type;

   typedef logic [NBR_W-1:0] nbr_type;

   typedef struct packed {
      logic       load_item;
      logic       pt_load;
      pt_sel_type pt_sel;
      nbr_type    nbr;
      logic       mem_write;
      logic       mem_read;
      logic       ok_hit;
      logic       ok_and;
      logic       read_cap;
      logic       count_acc;
      logic       sweep_write;
      logic       sweep_zero;
      logic       res_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     border;
      logic     hit;
      logic     rect_empty;
      logic     fill_last;
      logic     sweep_last;
      logic     out_free;
   } status_type;

   // Neighbors 0 to 3 are the cardinal ones, 4 to 7 the diagonal ones.
   function automatic logic signed [PT_W-1:0] nbr_dx(input nbr_type k);
      logic signed [PT_W-1:0] d;
      case (k)
         3'd0, 3'd4, 3'd6: d = -9'sd1;
         3'd1, 3'd5, 3'd7: d = 9'sd1;
         default:          d = 9'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [PT_W-1:0] nbr_dy(input nbr_type k);
      logic signed [PT_W-1:0] d;
      case (k)
         3'd2, 3'd4, 3'd5: d = -9'sd1;
         3'd3, 3'd6, 3'd7: d = 9'sd1;
         default:          d = 9'sd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/core/cgs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the cell codes of the grid store.
`default_nettype none

module cgs_ram #(
   parameter int DATA_W = 4,
   parameter int DEPTH  = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/cgs_ctrl.sv]
// Controller state machine of the cell grid store: sequences accesses,
// fills, sweeps and result hand-off. Depends on cgs_pkg.
`default_nettype none

module cgs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire cgs_pkg::status_type st,
   output cgs_pkg::cmd_type         cmd
);
   import cgs_pkg::*;

   typedef enum logic [9:0] {
      S_INIT   = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_DECODE = 10'b0000000100,
      S_PROD   = 10'b0000001000,
      S_ACC    = 10'b0000010000,
      S_DATA   = 10'b0000100000,
      S_FPROD  = 10'b0001000000,
      S_FACC   = 10'b0010000000,
      S_CLEAR  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   localparam nbr_type STEP_CORNER1 = 3'd0;
   localparam nbr_type STEP_CORNER2 = 3'd1;

   state_type state_ff, state_in;
   nbr_type   step_ff, step_in;
   nbr_type   nbr_first, nbr_last;

   assign nbr_first = (st.mode == MODE_DIAG) ? NBR_DIAG_FIRST : NBR_CARD_FIRST;
   assign nbr_last  = (st.mode == MODE_CARD) ? NBR_CARD_LAST : NBR_DIAG_LAST;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_zero  = 1'b1;
            if (st.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.mode)
               MODE_WRITE, MODE_READ, MODE_FILL: begin
                  step_in     = STEP_CORNER1;
                  cmd.pt_load = 1'b1;
                  cmd.pt_sel  = PT_CENTER;
                  state_in    = S_PROD;
               end
               MODE_CARD, MODE_DIAG, MODE_ALL: begin
                  if (st.border) begin
                     state_in = S_DONE;
                  end else begin
                     step_in     = nbr_first;
                     cmd.pt_load = 1'b1;
                     cmd.pt_sel  = PT_NBR;
                     cmd.nbr     = nbr_first;
                     state_in    = S_PROD;
                  end
               end
               MODE_CLEAR: begin
                  state_in = S_CLEAR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_PROD: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            case (st.mode)
               MODE_WRITE: begin
                  cmd.mem_write = 1'b1;
                  cmd.ok_hit    = 1'b1;
                  state_in      = S_DONE;
               end
               MODE_READ: begin
                  cmd.mem_read = 1'b1;
                  cmd.ok_hit   = 1'b1;
                  state_in     = S_DATA;
               end
               MODE_FILL: begin
                  cmd.ok_hit = 1'b1;
                  if (!st.hit) begin
                     state_in = S_DONE;
                  end else if (step_ff == STEP_CORNER1) begin
                     step_in     = STEP_CORNER2;
                     cmd.pt_load = 1'b1;
                     cmd.pt_sel  = PT_CORNER2;
                     state_in    = S_PROD;
                  end else if (st.rect_empty) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.pt_load = 1'b1;
                     cmd.pt_sel  = PT_FILL_START;
                     state_in    = S_FPROD;
                  end
               end
               MODE_CARD, MODE_DIAG, MODE_ALL: begin
                  cmd.mem_read = 1'b1;
                  state_in     = S_DATA;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DATA: begin
            case (st.mode)
               MODE_READ: begin
                  cmd.read_cap = 1'b1;
                  state_in     = S_DONE;
               end
               MODE_CARD, MODE_DIAG, MODE_ALL: begin
                  cmd.count_acc = 1'b1;
                  if (step_ff == nbr_last) begin
                     state_in = S_DONE;
                  end else begin
                     step_in     = step_ff + 3'd1;
                     cmd.pt_load = 1'b1;
                     cmd.pt_sel  = PT_NBR;
                     cmd.nbr     = step_ff + 3'd1;
                     state_in    = S_PROD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FPROD: begin
            state_in = S_FACC;
         end
         S_FACC: begin
            cmd.mem_write = 1'b1;
            cmd.ok_and    = 1'b1;
            if (st.fill_last) begin
               state_in = S_DONE;
            end else begin
               cmd.pt_load = 1'b1;
               cmd.pt_sel  = PT_FILL_NEXT;
               state_in    = S_FPROD;
            end
         end
         S_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (st.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTH
   a_acc_after_prod: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |-> $past(state_ff) == S_PROD)
      else $error("access phase entered without a product cycle");

   a_facc_after_fprod: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FACC |-> $past(state_ff) == S_FPROD)
      else $error("fill write entered without a product cycle");

   a_data_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA |-> $past(cmd.mem_read))
      else $error("data phase without a preceding memory read");
`endif

endmodule

`default_nettype wire

[rtl/core/cgs_dp.sv]
// Datapath of the cell grid store: configuration registers, item registers,
// address unit, cell memory, counters and the result register.
// Depends on cgs_pkg and cgs_ram.
`default_nettype none

module cgs_dp #(
   parameter int MAX_WIDTH = cgs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_DEPTH = cgs_pkg::MAX_DEPTH_DEF,
   parameter int CELL_BITS = cgs_pkg::CELL_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [cgs_pkg::REG_IDX_W-1:0]      csr_index,
   input  wire logic [cgs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic [cgs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [cgs_pkg::MODE_W-1:0]         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [cgs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire cgs_pkg::cmd_type                   cmd,
   output cgs_pkg::status_type                     st
);
   import cgs_pkg::*;

   localparam int STORE  = MAX_WIDTH * MAX_DEPTH;
   localparam int ADDR_W = $clog2(STORE);
   localparam int EXT_W  = CELL_BITS + CODE_W;

   logic [GEO_W-1:0]  width_ff, depth_ff;
   logic [CODE_W-1:0] floor_ff, empty_ff, invalid_ff;
   logic [GEO_W-1:0]  eff_w, eff_d;
   logic [SIZE_W-1:0] size_ff;

   mode_type                  mode_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, ex_ff, ey_ff;
   logic [CODE_W-1:0]         value_ff;

   logic signed [PT_W-1:0]    xs, ys, exs, eys, wm1, dm1;
   logic signed [COORD_W-1:0] fx0, fx1, fy0, fy1;
   logic signed [PT_W-1:0]    fx0e, fx1e, fy0e, fy1e;
   logic signed [PT_W-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [IDX_W-1:0]   idx;
   logic                      hit, hit_ff;
   logic [ADDR_W-1:0]         sweep_ff, mem_addr;
   logic                      sweep_last;

   logic [EXT_W-1:0]     value_ext, empty_ext, floor_ext, invalid_ext, rd_ext;
   logic [CELL_BITS-1:0] value_st, empty_st, floor_st, invalid_st, rd_data, rd_st;
   logic                 mem_wr_en;
   logic [CELL_BITS-1:0] mem_wr_data;
   logic                 floor_hit;

   logic              ok_ff;
   logic [CODE_W-1:0] rv_ff, cnt_ff;
   logic              res_ok;
   logic [CODE_W-1:0] res_rv, res_cnt;
   logic              rsp_valid_ff, rsp_valid_in, rsp_ok_ff;
   logic [CODE_W-1:0] rsp_rv_ff, rsp_cnt_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= '0;
         depth_ff   <= '0;
         floor_ff   <= FLOOR_RST;
         empty_ff   <= EMPTY_RST;
         invalid_ff <= INVALID_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WIDTH:   width_ff   <= csr_data;
            REG_DEPTH:   depth_ff   <= csr_data;
            REG_FLOOR:   floor_ff   <= csr_data[CODE_W-1:0];
            REG_EMPTY:   empty_ff   <= csr_data[CODE_W-1:0];
            REG_INVALID: invalid_ff <= csr_data[CODE_W-1:0];
            default:     ;
         endcase
      end
   end

   assign eff_w = ({1'b0, width_ff} > 8'(MAX_WIDTH)) ? GEO_W'(MAX_WIDTH) : width_ff;
   assign eff_d = ({1'b0, depth_ff} > 8'(MAX_DEPTH)) ? GEO_W'(MAX_DEPTH) : depth_ff;

   always_ff @(posedge clock) begin
      size_ff <= SIZE_W'(eff_w) * SIZE_W'(eff_d);
   end

   // Item registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= mode_type'(req_tuser);
         x_ff     <= req_tdata[7:0];
         y_ff     <= req_tdata[15:8];
         ex_ff    <= req_tdata[23:16];
         ey_ff    <= req_tdata[31:24];
         value_ff <= req_tdata[35:32];
      end
   end

   // Codes in stored form.
   assign value_ext   = EXT_W'(value_ff);
   assign empty_ext   = EXT_W'(empty_ff);
   assign floor_ext   = EXT_W'(floor_ff);
   assign invalid_ext = EXT_W'(invalid_ff);
   assign value_st    = value_ext[CELL_BITS-1:0];
   assign empty_st    = empty_ext[CELL_BITS-1:0];
   assign floor_st    = floor_ext[CELL_BITS-1:0];
   assign invalid_st  = invalid_ext[CELL_BITS-1:0];

   assign xs  = {x_ff[COORD_W-1], x_ff};
   assign ys  = {y_ff[COORD_W-1], y_ff};
   assign exs = {ex_ff[COORD_W-1], ex_ff};
   assign eys = {ey_ff[COORD_W-1], ey_ff};
   assign wm1 = $signed({2'b00, eff_w}) - 9'sd1;
   assign dm1 = $signed({2'b00, eff_d}) - 9'sd1;

   assign fx0  = (x_ff < ex_ff) ? x_ff : ex_ff;
   assign fx1  = (x_ff < ex_ff) ? ex_ff : x_ff;
   assign fy0  = (y_ff < ey_ff) ? y_ff : ey_ff;
   assign fy1  = (y_ff < ey_ff) ? ey_ff : y_ff;
   assign fx0e = {fx0[COORD_W-1], fx0};
   assign fx1e = {fx1[COORD_W-1], fx1};
   assign fy0e = {fy0[COORD_W-1], fy0};
   assign fy1e = {fy1[COORD_W-1], fy1};

   // Coordinate under access.
   always_comb begin
      ax_in = ax_ff;
      ay_in = ay_ff;
      if (cmd.pt_load) begin
         case (cmd.pt_sel)
            PT_CENTER: begin
               ax_in = xs;
               ay_in = ys;
            end
            PT_NBR: begin
               ax_in = xs + nbr_dx(cmd.nbr);
               ay_in = ys + nbr_dy(cmd.nbr);
            end
            PT_CORNER2: begin
               ax_in = exs;
               ay_in = eys;
            end
            PT_FILL_START: begin
               ax_in = fx0e;
               ay_in = fy0e;
            end
            PT_FILL_NEXT: begin
               if (ay_ff + 9'sd1 == fy1e) begin
                  ay_in = fy0e;
                  ax_in = ax_ff + 9'sd1;
               end else begin
                  ay_in = ay_ff + 9'sd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      prod_ff <= $signed({{(PROD_W-PT_W){ay_ff[PT_W-1]}}, ay_ff})
               * $signed({{(PROD_W-GEO_W){1'b0}}, eff_w});
      hit_ff  <= hit;
   end

   assign idx = $signed({{(IDX_W-PT_W){ax_ff[PT_W-1]}}, ax_ff})
              + $signed({{(IDX_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
   assign hit = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(size_ff));

   // Sweep counter for the clearing passes.
   assign sweep_last = (sweep_ff == ADDR_W'(STORE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_write) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   assign mem_addr    = cmd.sweep_write ? sweep_ff : idx[ADDR_W-1:0];
   assign mem_wr_en   = cmd.sweep_write || (cmd.mem_write && hit);
   assign mem_wr_data = cmd.sweep_write ? (cmd.sweep_zero ? '0 : empty_st) : value_st;

   cgs_ram #(
      .DATA_W (CELL_BITS),
      .DEPTH  (STORE)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   assign rd_st     = hit_ff ? rd_data : invalid_st;
   assign rd_ext    = EXT_W'(rd_st);
   assign floor_hit = (rd_st == floor_st);

   always_ff @(posedge clock) begin
      if (cmd.ok_hit) begin
         ok_ff <= hit;
      end else if (cmd.ok_and) begin
         ok_ff <= ok_ff && hit;
      end
      if (cmd.read_cap) begin
         rv_ff <= rd_ext[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_item) begin
         cnt_ff <= '0;
      end else if (cmd.count_acc) begin
         cnt_ff <= cnt_ff + CODE_W'(floor_hit);
      end
   end

   // Result selection and output register.
   always_comb begin
      res_ok  = 1'b0;
      res_rv  = '0;
      res_cnt = '0;
      case (mode_ff)
         MODE_WRITE, MODE_FILL: res_ok = ok_ff;
         MODE_READ: begin
            res_ok = ok_ff;
            res_rv = rv_ff;
         end
         MODE_CARD, MODE_DIAG: res_cnt = st.border ? CARD_BORDER : cnt_ff;
         MODE_ALL:             res_cnt = st.border ? ALL_BORDER : cnt_ff;
         MODE_CLEAR:           res_ok  = 1'b1;
         default:              ;
      endcase
   end

   assign rsp_valid_in = cmd.res_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_ok_ff  <= res_ok;
         rsp_rv_ff  <= res_rv;
         rsp_cnt_ff <= res_cnt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*CODE_W-1){1'b0}}, rsp_cnt_ff, rsp_rv_ff, rsp_ok_ff};

   assign st.mode       = mode_ff;
   assign st.border     = (xs <= 9'sd0) || (ys <= 9'sd0) || (xs >= wm1) || (ys >= dm1);
   assign st.hit        = hit;
   assign st.rect_empty = (x_ff == ex_ff) || (y_ff == ey_ff);
   assign st.fill_last  = (ay_ff + 9'sd1 == fy1e) && (ax_ff + 9'sd1 == fx1e);
   assign st.sweep_last = sweep_last;
   assign st.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8)
      else $error("neighbor count above eight");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("response word changed while stalled");
`endif

endmodule

`default_nettype wire

[rtl/core/cell_grid_store_with_neighbour_count_unit.sv]
// Top level of the cell grid store with neighbor counts.
// Joins the controller and the datapath; depends on cgs_pkg, cgs_ctrl, cgs_dp.
//
// Usage: one request word on the req_ channel carries the mode in req_tuser and
// the coordinates and code in req_tdata. Each request gives exactly one response
// word on the rsp_ channel. Configuration registers are written on the csr_
// channel, which is always ready; the user must write them only while no
// request is in flight, as the block itself does not enforce it.
// A count on the border goes straight to the result without a memory access.
// The controller handles one request at a time through a product state, an
// access state and, for reads and counts, a data state per cell on the single
// memory port, so a new request is taken in the cycle after the previous
// result is loaded.
// After reset the memory is swept to code zero, all MAX_WIDTH*MAX_DEPTH cells
// (4096 by default), with req_tready low.
// When the receiver stalls, the result waits in the output register; one more
// request is taken and its result is held back until the register frees.
`default_nettype none

module cell_grid_store_with_neighbour_count_unit #(
   parameter int MAX_WIDTH = cgs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_DEPTH = cgs_pkg::MAX_DEPTH_DEF,
   parameter int CELL_BITS = cgs_pkg::CELL_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration write channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cgs_pkg::REG_IDX_W-1:0]      csr_index,
   input  wire logic [cgs_pkg::CSR_DATA_W-1:0]     csr_data,
   // Request channel.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // cell_x[7:0], cell_y[15:8], end_x[23:16], end_y[31:24], cell_value[35:32].
   input  wire logic [cgs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[2:0].
   input  wire logic [cgs_pkg::MODE_W-1:0]         req_tuser,
   // Response channel.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // ok[0], read_value[4:1], neighbour_count[8:5].
   output logic      [cgs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cgs_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   cgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   cgs_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_DEPTH (MAX_DEPTH),
      .CELL_BITS (CELL_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the cell grid store with neighbor counts.
// Depends on cgs_pkg and cell_grid_store_with_neighbour_count_unit; drives request
// and configuration words and checks every response word against an in-bench model.
`timescale 1ns / 100ps

module tb;
   import cgs_pkg::*;

   localparam int STALL_LIMIT = 600000;
   localparam int LONG_HOLD   = 300;
   localparam int STORE_CELLS = MAX_WIDTH_DEF * MAX_DEPTH_DEF;

   typedef struct {
      mode_type   mode;
      logic [7:0] cx;
      logic [7:0] cy;
      logic [7:0] ex;
      logic [7:0] ey;
      logic [3:0] val;
   } grid_cmd_type;

   typedef struct {
      logic       ok;
      logic [3:0] rd;
      logic [3:0] cnt;
   } grid_rsp_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [REG_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [MODE_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   // Model state: stored cells and the register copies.
   logic [3:0] grid_cells [0:STORE_CELLS-1];
   int         geo_w;
   int         geo_d;
   logic [3:0] floor_c;
   logic [3:0] empty_c;
   logic [3:0] invalid_c;

   grid_rsp_type pending_rsp [$];
   grid_rsp_type rsp_want;
   int           mismatches = 0;
   int           rsp_seen = 0;
   int           idle_cycles = 0;
   bit           quiet;
   bit           long_hold;

   cell_grid_store_with_neighbour_count_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit cell_in_grid(input int idx);
      return idx >= 0 && idx < geo_w * geo_d;
   endfunction

   function automatic logic [3:0] cell_at(input int x, input int y);
      int idx = x + y * geo_w;
      if (cell_in_grid(idx)) return grid_cells[idx];
      return invalid_c;
   endfunction

   function automatic int floor_at(input int x, input int y);
      return (cell_at(x, y) == floor_c) ? 1 : 0;
   endfunction

   function automatic int card_floor(input int x, input int y);
      return floor_at(x - 1, y) + floor_at(x + 1, y) + floor_at(x, y - 1) + floor_at(x, y + 1);
   endfunction

   function automatic int diag_floor(input int x, input int y);
      return floor_at(x - 1, y - 1) + floor_at(x + 1, y - 1) +
             floor_at(x - 1, y + 1) + floor_at(x + 1, y + 1);
   endfunction

   function automatic bit at_border(input int x, input int y);
      return x <= 0 || y <= 0 || x >= geo_w - 1 || y >= geo_d - 1;
   endfunction

   function automatic grid_rsp_type predict_grid(input grid_cmd_type c);
      grid_rsp_type r;
      int x, y, ex, ey, x0, x1, y0, y1, idx;
      r.ok = 1'b0;
      r.rd = 4'd0;
      r.cnt = 4'd0;
      x = int'($signed(c.cx));
      y = int'($signed(c.cy));
      ex = int'($signed(c.ex));
      ey = int'($signed(c.ey));
      case (c.mode)
         MODE_WRITE: begin
            idx = x + y * geo_w;
            if (cell_in_grid(idx)) begin
               grid_cells[idx] = c.val;
               r.ok = 1'b1;
            end
         end
         MODE_READ: begin
            r.ok = cell_in_grid(x + y * geo_w);
            r.rd = cell_at(x, y);
         end
         MODE_FILL: begin
            if (cell_in_grid(x + y * geo_w) && cell_in_grid(ex + ey * geo_w)) begin
               r.ok = 1'b1;
               x0 = (x < ex) ? x : ex;
               x1 = (x < ex) ? ex : x;
               y0 = (y < ey) ? y : ey;
               y1 = (y < ey) ? ey : y;
               for (int i = x0; i < x1; i++) begin
                  for (int j = y0; j < y1; j++) begin
                     idx = i + j * geo_w;
                     if (cell_in_grid(idx)) grid_cells[idx] = c.val;
                     else r.ok = 1'b0;
                  end
               end
            end
         end
         MODE_CARD: r.cnt = at_border(x, y) ? CARD_BORDER : 4'(card_floor(x, y));
         MODE_DIAG: r.cnt = at_border(x, y) ? CARD_BORDER : 4'(diag_floor(x, y));
         MODE_ALL: begin
            r.cnt = at_border(x, y) ? ALL_BORDER : 4'(card_floor(x, y) + diag_floor(x, y));
         end
         MODE_CLEAR: begin
            for (int i = 0; i < STORE_CELLS; i++) grid_cells[i] = empty_c;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx, input int value);
      case (idx)
         REG_WIDTH:   geo_w = (value > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : value;
         REG_DEPTH:   geo_d = (value > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : value;
         REG_FLOOR:   floor_c = value[3:0];
         REG_EMPTY:   empty_c = value[3:0];
         REG_INVALID: invalid_c = value[3:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_coord(input int span);
      int r = $urandom_range(0, 9);
      if (r == 0) return int'($urandom_range(0, 255)) - 128;
      if (r == 1) return span + int'($urandom_range(0, 3));
      return int'($urandom_range(0, span + 1)) - 1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on response %0d: %s got %0d expected %0d", rsp_seen, what, got, want);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input int w, input int d, input int fl, input int em, input int inv);
      write_reg(REG_WIDTH, w);
      write_reg(REG_DEPTH, d);
      write_reg(REG_FLOOR, fl);
      write_reg(REG_EMPTY, em);
      write_reg(REG_INVALID, inv);
   endtask

   task automatic send_cmd(input mode_type m, input int x, input int y, input int ex,
                           input int ey, input int v);
      grid_cmd_type c;
      int gap;
      c.mode = m;
      c.cx = x[7:0];
      c.cy = y[7:0];
      c.ex = ex[7:0];
      c.ey = ey[7:0];
      c.val = v[3:0];
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.mode;
      req_tdata <= {4'd0, c.val, c.ey, c.ex, c.cy, c.cx};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_grid(c));
   endtask

   task automatic send_random();
      int pick, sx, sy, ex, ey, v;
      mode_type m;
      pick = $urandom_range(0, 199);
      if (pick < 2) m = MODE_CLEAR;
      else if (pick < 52) m = MODE_WRITE;
      else if (pick < 82) m = MODE_READ;
      else if (pick < 106) m = MODE_FILL;
      else if (pick < 138) m = MODE_CARD;
      else if (pick < 170) m = MODE_DIAG;
      else m = MODE_ALL;
      sx = pick_coord(geo_w);
      sy = pick_coord(geo_d);
      if (m == MODE_FILL && $urandom_range(0, 19) != 0) begin
         ex = sx + int'($urandom_range(0, 10)) - 5;
         ey = sy + int'($urandom_range(0, 10)) - 5;
      end else begin
         ex = pick_coord(geo_w);
         ey = pick_coord(geo_d);
      end
      v = ($urandom_range(0, 1) == 0) ? int'(floor_c) : int'($urandom_range(0, 15));
      send_cmd(m, sx, sy, ex, ey, v);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int w, input int d, input int fl, input int em,
                            input int inv, input int n);
      wait_drained();
      set_grid(w, d, fl, em, inv);
      for (int k = 0; k < n; k++) begin
         if (k == n / 2) wait_drained();
         send_random();
      end
   endtask

   task automatic test_reset_defaults();
      send_cmd(MODE_READ, 0, 0, 0, 0, 0);
      send_cmd(MODE_CARD, 3, 3, 0, 0, 0);
      send_cmd(MODE_WRITE, 0, 0, 0, 0, 9);
      wait_drained();
      set_grid(8, 6, 1, 0, 15);
      send_cmd(MODE_READ, 0, 0, 0, 0, 0);
      send_cmd(MODE_READ, 7, 5, 0, 0, 0);
      send_cmd(MODE_ALL, 3, 3, 0, 0, 0);
   endtask

   task automatic test_directed_cases();
      wait_drained();
      set_grid(8, 6, 1, 0, 15);
      send_cmd(MODE_WRITE, 0, 0, 0, 0, 15);
      send_cmd(MODE_WRITE, 7, 5, 0, 0, 1);
      send_cmd(MODE_READ, 7, 5, 0, 0, 0);
      send_cmd(MODE_READ, 0, 0, 0, 0, 0);
      send_cmd(MODE_WRITE, 9, 0, 0, 0, 1);
      send_cmd(MODE_READ, 1, 1, 0, 0, 0);
      send_cmd(MODE_READ, -128, -128, 0, 0, 0);
      send_cmd(MODE_WRITE, 127, 127, 0, 0, 4);
      send_cmd(MODE_READ, -1, 1, 0, 0, 0);
      send_cmd(MODE_FILL, 1, 1, 4, 4, 1);
      send_cmd(MODE_FILL, 2, 2, 2, 4, 6);
      send_cmd(MODE_FILL, 0, 0, 8, 6, 2);
      send_cmd(MODE_FILL, -1, 1, 2, 0, 3);
      send_cmd(MODE_CARD, 2, 2, 0, 0, 0);
      send_cmd(MODE_DIAG, 2, 2, 0, 0, 0);
      send_cmd(MODE_ALL, 3, 3, 0, 0, 0);
      send_cmd(MODE_CARD, 0, 3, 0, 0, 0);
      send_cmd(MODE_DIAG, 3, 5, 0, 0, 0);
      send_cmd(MODE_ALL, 7, 2, 0, 0, 0);
      send_cmd(MODE_ALL, 6, 4, 0, 0, 0);
      send_cmd(MODE_CLEAR, 0, 0, 0, 0, 0);
      send_cmd(MODE_READ, 3, 3, 0, 0, 0);
      wait_drained();
      set_grid(8, 6, 5, 5, 0);
      send_cmd(MODE_CLEAR, 0, 0, 0, 0, 0);
      send_cmd(MODE_ALL, 3, 3, 0, 0, 0);
      send_cmd(MODE_READ, -1, -1, 0, 0, 0);
      send_cmd(MODE_READ, 2, 2, 0, 0, 0);
   endtask

   task automatic test_geometry_extremes();
      wait_drained();
      set_grid(64, 64, 2, 0, 15);
      send_cmd(MODE_FILL, 0, 0, 63, 63, 2);
      send_cmd(MODE_READ, 63, 63, 0, 0, 0);
      send_cmd(MODE_READ, 62, 62, 0, 0, 0);
      send_cmd(MODE_ALL, 62, 62, 0, 0, 0);
      send_cmd(MODE_CARD, 1, 1, 0, 0, 0);
      send_cmd(MODE_READ, 63, 64, 0, 0, 0);
      send_cmd(MODE_WRITE, 127, 62, 0, 0, 8);
      send_cmd(MODE_WRITE, 127, 63, 0, 0, 8);
      send_cmd(MODE_READ, -128, 127, 0, 0, 0);
      wait_drained();
      set_grid(0, 0, 0, 15, 0);
      send_cmd(MODE_READ, 0, 0, 0, 0, 0);
      send_cmd(MODE_WRITE, 0, 0, 0, 0, 3);
      send_cmd(MODE_FILL, 0, 0, 0, 0, 3);
      send_cmd(MODE_CARD, 1, 1, 0, 0, 0);
      send_cmd(MODE_DIAG, 1, 1, 0, 0, 0);
      send_cmd(MODE_ALL, 1, 1, 0, 0, 0);
      wait_drained();
      set_grid(5, 0, 15, 0, 7);
      send_cmd(MODE_READ, 0, 0, 0, 0, 0);
      send_cmd(MODE_ALL, 2, 2, 0, 0, 0);
      wait_drained();
      set_grid(64, 1, 2, 0, 15);
      send_cmd(MODE_READ, 63, 0, 0, 0, 0);
      send_cmd(MODE_WRITE, 64, 0, 0, 0, 2);
      send_cmd(MODE_FILL, 0, 0, 63, 0, 9);
   endtask

   task automatic test_random_grids();
      run_phase(8, 8, 1, 0, 15, 250);
      run_phase(13, 7, 15, 15, 0, 250);
      run_phase(3, 3, 0, 7, 9, 80);
      run_phase(64, 64, 6, 3, 12, 200);
      run_phase(64, 1, 4, 2, 11, 60);
      run_phase(1, 64, 9, 1, 14, 60);
      run_phase(0, 9, 1, 0, 15, 40);
      run_phase(2, 2, 1, 0, 15, 60);
      run_phase(37, 50, 7, 7, 8, 160);
   endtask

   task automatic test_backpressure();
      wait_drained();
      set_grid(10, 10, 1, 0, 15);
      long_hold = 1'b1;
      repeat (16) send_random();
      wait_drained();
   endtask

   task automatic test_quiet_tail();
      wait_drained();
      quiet = 1'b1;
      set_grid(16, 12, 3, 0, 15);
      repeat (150) send_random();
      wait_drained();
   endtask

   // The receiver idles in bursts and, on request, holds off for a long stretch.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            rsp_want = pending_rsp.pop_front();
            if (rsp_tdata[0] !== rsp_want.ok) report_mismatch("ok", rsp_tdata[0], rsp_want.ok);
            if (rsp_tdata[4:1] !== rsp_want.rd)
               report_mismatch("read_value", rsp_tdata[4:1], rsp_want.rd);
            if (rsp_tdata[8:5] !== rsp_want.cnt)
               report_mismatch("neighbour_count", rsp_tdata[8:5], rsp_want.cnt);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_WRITE;
      quiet = 1'b0;
      long_hold = 1'b0;
      geo_w = 0;
      geo_d = 0;
      floor_c = FLOOR_RST;
      empty_c = EMPTY_RST;
      invalid_c = INVALID_RST;
      for (int i = 0; i < STORE_CELLS; i++) grid_cells[i] = EMPTY_RST;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_geometry_extremes();
      test_random_grids();
      test_backpressure();
      test_quiet_tail();

      repeat (30) @(posedge clock);
      if (pending_rsp.size() != 0) report_mismatch("words never returned", 0, pending_rsp.size());
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[cell_grid_store_with_neighbour_count_unit.f]
rtl/core/cgs_pkg.sv
rtl/core/cgs_ram.sv
rtl/core/cgs_ctrl.sv
rtl/core/cgs_dp.sv
rtl/core/cell_grid_store_with_neighbour_count_unit.sv
tb/sv/tb.sv
